@@ hw/rtl/chsp_pkg.sv @@
// shared opcode and status codes and item types for the chained hash set pool
package chsp_pkg;

	localparam int unsigned KEY_W    = 32;
	localparam int unsigned OPCODE_W = 2;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned INDEX_W  = 12;
	localparam int unsigned COUNT_W  = 13;

	typedef enum logic [OPCODE_W-1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_READ   = 2'd2,
		OP_NOP    = 2'd3
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_BEYOND    = 2'd3
	} status_t;

	// one input item
	typedef struct packed {
		opcode_t                   opcode;
		logic signed [KEY_W-1:0]   key;
		logic [INDEX_W-1:0]        index;
	} req_t;

	// one result item
	typedef struct packed {
		status_t                   status;
		logic signed [KEY_W-1:0]   key_out;
		logic [COUNT_W-1:0]        count;
	} rsp_t;

endpackage

@@ hw/rtl/chsp_if.sv @@
// valid/ready channel carrying one item with a generic payload
interface chsp_if #(
	parameter type payload_t = logic
) (
	input logic clk
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/chsp_node_mem.sv @@
// node pool memory: key and link per slot, one write and one registered read per cycle
module chsp_node_mem #(
	parameter int unsigned AW = 12,
	parameter int unsigned LW = 13
) (
	input  logic                        clk,
	input  logic                        kwe,
	input  logic                        lwe,
	input  logic [AW-1:0]               waddr,
	input  logic [chsp_pkg::KEY_W-1:0]  wkey,
	input  logic [LW-1:0]               wlink,
	input  logic [AW-1:0]               raddr,
	output logic [chsp_pkg::KEY_W-1:0]  rkey,
	output logic [LW-1:0]               rlink
);
	logic [chsp_pkg::KEY_W-1:0] keys_mem [2**AW];
	logic [LW-1:0]              links_mem [2**AW];

	// write port, key and link enabled separately
	always_ff @(posedge clk) begin
		if (kwe) keys_mem[waddr] <= wkey;
		if (lwe) links_mem[waddr] <= wlink;
	end

	// registered read port
	always_ff @(posedge clk) begin
		rkey  <= keys_mem[raddr];
		rlink <= links_mem[raddr];
	end
endmodule

@@ hw/rtl/chsp_head_mem.sv @@
// bucket head memory with a clearing pass after reset
module chsp_head_mem #(
	parameter int unsigned BW         = 10,
	parameter int unsigned LW         = 13,
	parameter int unsigned EMPTY_CODE = 4096
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          we,
	input  logic [BW-1:0] waddr,
	input  logic [LW-1:0] wdata,
	input  logic [BW-1:0] raddr,
	output logic [LW-1:0] rdata,
	output logic          busy
);
	logic [LW-1:0] heads_mem [2**BW];
	logic [BW-1:0] clr_addr_q;
	logic          clr_q;

	// clearing pass writes the empty code to every bucket
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == {BW{1'b1}}) clr_q <= 1'b0;
		end
	end

	// write and registered read
	always_ff @(posedge clk) begin
		if (clr_q) heads_mem[clr_addr_q] <= LW'(EMPTY_CODE);
		else if (we) heads_mem[waddr] <= wdata;
		rdata <= heads_mem[raddr];
	end

	assign busy = clr_q;
endmodule

@@ hw/rtl/chained_hash_set_pool_unit.sv @@
// Chained hash multiset: one item in, one result out, one item in flight at a time. A new
// item is accepted only once the previous result has been taken by the receiver. An unused
// opcode goes straight to the result. A delete walks the key's bucket chain until it hits or
// the chain ends; on a hit it unlinks the node and, unless the hit was the last pool node,
// reads the last node, walks that node's own chain to find the reference to it, moves it into
// the freed slot and repoints that reference. Each chain node costs one registered read of
// the node memory. After reset the bucket head memory is cleared, one bucket per cycle, while
// no item is accepted.
// POOL_DEPTH may be any value from 2 to 4096, the range the 12-bit index can address.
module chained_hash_set_pool_unit #(
	parameter int unsigned BUCKET_BITS = 10,
	parameter int unsigned POOL_DEPTH  = 4096
) (
	input logic clk,
	input logic arst_n,
	chsp_if.sink   in_ch,
	chsp_if.source out_ch
);
	localparam int unsigned AW = $clog2(POOL_DEPTH);
	localparam int unsigned LW = AW + 1;
	localparam int unsigned CW = chsp_pkg::COUNT_W;
	localparam logic [LW-1:0] EMPTY = LW'(POOL_DEPTH);

	typedef enum logic [3:0] {
		S_IDLE, S_HEAD, S_WALK, S_UNLINK, S_LASTRD, S_LHEAD, S_LWALK, S_RELINK, S_READ, S_OUT
	} state_t;

	state_t                          state_q;
	chsp_pkg::opcode_t               op_q;
	logic [chsp_pkg::KEY_W-1:0]      key_q;
	logic [chsp_pkg::INDEX_W-1:0]    idx_q;
	logic [LW-1:0]                   count_q;
	logic [LW-1:0]                   cur_q, prev_q, hit_q, last_q, steps_q;
	logic [LW-1:0]                   hlink_q;
	logic [chsp_pkg::KEY_W-1:0]      lkey_q;
	logic [LW-1:0]                   llink_q;
	chsp_pkg::status_t               status_q;
	logic [chsp_pkg::KEY_W-1:0]      kout_q;
	logic                            ovalid_q;

	// memory ports
	logic                        hwe, kwe, lwe, hbusy;
	logic [BUCKET_BITS-1:0]      hwaddr, hraddr;
	logic [LW-1:0]               hwdata, hrdata;
	logic [AW-1:0]               nwaddr, nraddr;
	logic [chsp_pkg::KEY_W-1:0]  nwkey, nrkey;
	logic [LW-1:0]               nwlink, nrlink;

	chsp_head_mem #(.BW(BUCKET_BITS), .LW(LW), .EMPTY_CODE(POOL_DEPTH)) u_heads (
		.clk, .arst_n, .we(hwe), .waddr(hwaddr), .wdata(hwdata),
		.raddr(hraddr), .rdata(hrdata), .busy(hbusy)
	);
	chsp_node_mem #(.AW(AW), .LW(LW)) u_nodes (
		.clk, .kwe(kwe), .lwe(lwe), .waddr(nwaddr), .wkey(nwkey), .wlink(nwlink),
		.raddr(nraddr), .rkey(nrkey), .rlink(nrlink)
	);

	logic [LW-1:0] next_cur;
	logic [LW-1:0] llink_fwd;
	logic          cur_live;
	logic          key_hit, last_hit;

	assign in_ch.ready  = (state_q == S_IDLE) && !hbusy && !ovalid_q;
	assign out_ch.valid = ovalid_q;
	assign out_ch.data  = {status_q, kout_q, CW'(count_q)};

	// the current walk pointer: a fresh head read or a link just read
	assign next_cur = (state_q == S_HEAD || state_q == S_LHEAD) ? hrdata : nrlink;
	assign cur_live = (next_cur < EMPTY) && (steps_q < EMPTY);
	assign key_hit  = nrkey == key_q;
	assign last_hit = cur_q == last_q;
	// the last node's link was read in the same cycle the unlink rewrote it
	assign llink_fwd = (prev_q != EMPTY && prev_q == last_q) ? hlink_q : nrlink;

	// memory addressing and writes
	always_comb begin
		hwe    = 1'b0;
		hwaddr = key_q[BUCKET_BITS-1:0];
		hwdata = EMPTY;
		hraddr = key_q[BUCKET_BITS-1:0];
		kwe    = 1'b0;
		lwe    = 1'b0;
		nwaddr = count_q[AW-1:0];
		nwkey  = key_q;
		nwlink = hrdata;
		nraddr = next_cur[AW-1:0];
		unique case (state_q)
			S_IDLE: begin
				hraddr = in_ch.data.key[BUCKET_BITS-1:0];
				nraddr = AW'(in_ch.data.index);
			end
			S_HEAD: begin
				// insert: link the new node to the old head and make it the head
				if (op_q == chsp_pkg::OP_INSERT && count_q < EMPTY) begin
					kwe    = 1'b1;
					lwe    = 1'b1;
					hwe    = 1'b1;
					hwdata = count_q;
				end
			end
			S_UNLINK: begin
				// bypass the hit node, then read the last node
				if (prev_q == EMPTY) begin
					hwe    = 1'b1;
					hwdata = hlink_q;
				end else begin
					lwe    = 1'b1;
					nwaddr = prev_q[AW-1:0];
					nwlink = hlink_q;
				end
				nraddr = last_q[AW-1:0];
			end
			S_LASTRD: begin
				hraddr = nrkey[BUCKET_BITS-1:0];
			end
			S_LWALK: begin
				// found the reference to the last node: move it into the freed slot
				if (last_hit) begin
					kwe    = 1'b1;
					lwe    = 1'b1;
					nwaddr = hit_q[AW-1:0];
					nwkey  = lkey_q;
					nwlink = llink_q;
				end
			end
			S_RELINK: begin
				// repoint the head or link that held the moved node
				if (prev_q == EMPTY) begin
					hwe    = 1'b1;
					hwaddr = lkey_q[BUCKET_BITS-1:0];
					hwdata = hit_q;
				end else begin
					lwe    = 1'b1;
					nwaddr = prev_q[AW-1:0];
					nwlink = hit_q;
				end
			end
			default: ;
		endcase
	end

	// the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) ovalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_ch.valid && in_ch.ready) begin
					op_q     <= in_ch.data.opcode;
					key_q    <= in_ch.data.key;
					idx_q    <= in_ch.data.index;
					steps_q  <= '0;
					prev_q   <= EMPTY;
					status_q <= chsp_pkg::ST_OK;
					kout_q   <= '0;
					unique case (in_ch.data.opcode)
						chsp_pkg::OP_INSERT, chsp_pkg::OP_DELETE: state_q <= S_HEAD;
						chsp_pkg::OP_READ: state_q <= S_READ;
						default: state_q <= S_OUT;
					endcase
				end
				S_READ: begin
					if (32'(idx_q) >= 32'(count_q)) status_q <= chsp_pkg::ST_BEYOND;
					else kout_q <= nrkey;
					state_q <= S_OUT;
				end
				S_HEAD: begin
					if (op_q == chsp_pkg::OP_INSERT) begin
						if (count_q < EMPTY) count_q <= count_q + 1'b1;
						else status_q <= chsp_pkg::ST_FULL;
						state_q <= S_OUT;
					end else if (cur_live) begin
						cur_q   <= next_cur;
						state_q <= S_WALK;
					end else begin
						status_q <= chsp_pkg::ST_NOT_FOUND;
						state_q  <= S_OUT;
					end
				end
				S_WALK: begin
					// node cur_q was read last cycle
					if (key_hit) begin
						hit_q   <= cur_q;
						hlink_q <= nrlink;
						last_q  <= count_q - 1'b1;
						count_q <= count_q - 1'b1;
						state_q <= S_UNLINK;
					end else begin
						steps_q <= steps_q + 1'b1;
						prev_q  <= cur_q;
						if (nrlink < EMPTY && (steps_q + 1'b1) < EMPTY) begin
							cur_q <= nrlink;
						end else begin
							status_q <= chsp_pkg::ST_NOT_FOUND;
							state_q  <= S_OUT;
						end
					end
				end
				S_UNLINK: begin
					if (last_q == hit_q) state_q <= S_OUT;
					else state_q <= S_LASTRD;
				end
				S_LASTRD: begin
					lkey_q  <= nrkey;
					llink_q <= llink_fwd;
					prev_q  <= EMPTY;
					steps_q <= '0;
					state_q <= S_LHEAD;
				end
				S_LHEAD: begin
					if (cur_live) begin
						cur_q   <= next_cur;
						state_q <= S_LWALK;
					end else state_q <= S_OUT;
				end
				S_LWALK: begin
					if (last_hit) begin
						state_q <= S_RELINK;
					end else begin
						steps_q <= steps_q + 1'b1;
						prev_q  <= cur_q;
						if (nrlink < EMPTY && (steps_q + 1'b1) < EMPTY) cur_q <= nrlink;
						else state_q <= S_OUT;
					end
				end
				S_RELINK: state_q <= S_OUT;
				S_OUT: begin
					ovalid_q <= 1'b1;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
